>>> hdl/ejs_pkg.sv
package ejs_pkg;

    // nesting stack depth and the width of the depth counter
    localparam int NEST_MAX = 128;
    localparam int DEPTH_W  = $clog2(NEST_MAX + 1);

    // most text bytes one item can cause
    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // item op codes
    localparam logic [3:0] OP_DOC_START    = 4'd0;
    localparam logic [3:0] OP_MAP_START    = 4'd1;
    localparam logic [3:0] OP_MAP_END      = 4'd2;
    localparam logic [3:0] OP_SEQ_START    = 4'd3;
    localparam logic [3:0] OP_SEQ_END      = 4'd4;
    localparam logic [3:0] OP_SCALAR_START = 4'd5;
    localparam logic [3:0] OP_SCALAR_BYTE  = 4'd6;
    localparam logic [3:0] OP_SCALAR_END   = 4'd7;
    localparam logic [3:0] OP_ALIAS        = 4'd8;

    // text characters
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_L  = 8'h6c;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // control bytes with short escapes
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_HT = 8'h09;
    localparam logic [7:0] CTL_LF = 8'h0a;
    localparam logic [7:0] CTL_FF = 8'h0c;
    localparam logic [7:0] CTL_CR = 8'h0d;

    typedef enum logic [1:0] {
        ROLE_NONE  = 2'd0,
        ROLE_KEY   = 2'd1,
        ROLE_VALUE = 2'd2,
        ROLE_SEQ   = 2'd3
    } role_t;

    typedef struct packed {
        role_t role;
        logic  nonempty;
    } frame_t;

    typedef struct packed {
        logic load_above;
        logic load_below;
    } cell_ctl_t;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      err;
    } ejs_load_t;

    // frame after one node of it has completed
    function automatic frame_t frame_advance(frame_t f);
        frame_t r;
        r = f;
        case (f.role)
            ROLE_KEY:   r.role = ROLE_VALUE;
            ROLE_VALUE:
            begin
                r.role     = ROLE_KEY;
                r.nonempty = 1'b1;
            end
            ROLE_SEQ:   r.nonempty = 1'b1;
            default:    r = f;
        endcase
        return r;
    endfunction

    // lowercase hex digit
    function automatic logic [7:0] hex_char(logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10)
            r = CH_ZERO + {4'b0, n};
        else
            r = 8'h57 + {4'b0, n};
        return r;
    endfunction

endpackage

>>> hdl/event_stream_json_emitter_unit.sv
// channel | signals                        | word
// --------+--------------------------------+----------------------------------
// in      | in_valid, in_ready             | op, data_byte
// out     | out_valid, out_ready           | out_byte, last, overflow_error
//
// one item is taken per cycle while it causes at most one text byte; an item
// causing n text bytes (2 to 6) keeps in_ready low after it is taken while
// the output byte line drains, the next item is taken in the cycle its last
// byte leaves. the nesting stack is a row of frame cells that shift on push
// and pop, so the top frame is always in the first cell.
// reset clears the depth, the error flag and the output line; frame contents
// are not reset. a stall on out holds in_ready low once the line is busy.
module event_stream_json_emitter_unit
    import ejs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] op,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       overflow_error
);

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               err_reg;
    logic               err_next;

    frame_t    cell_frame [NEST_MAX];
    frame_t    cell_below [NEST_MAX];
    frame_t    top_new;
    logic      top_we;
    logic      do_push;
    logic      do_pop;
    logic      accept;
    logic      has_top;
    logic      full;
    logic      sep_en;
    logic [7:0] sep_ch;
    logic [MAX_BYTES-1:0][7:0] body;
    logic [CNT_W-1:0]          body_n;
    ejs_load_t load_data;
    logic      free;

    assign accept  = in_valid && in_ready;
    assign in_ready = free;
    assign has_top = (depth_reg != '0);
    assign full    = (depth_reg == DEPTH_W'(NEST_MAX));

    // separator before a node
    always_comb
    begin
        sep_en = 1'b0;
        sep_ch = CH_COMMA;
        if (has_top)
        begin
            case (cell_frame[0].role)
                ROLE_KEY, ROLE_SEQ:
                    sep_en = cell_frame[0].nonempty;
                ROLE_VALUE:
                begin
                    sep_en = 1'b1;
                    sep_ch = CH_COLON;
                end
                default: sep_en = 1'b0;
            endcase
        end
    end

    // item decode, stack control and text bytes
    always_comb
    begin
        depth_next = depth_reg;
        err_next   = err_reg;
        top_we     = 1'b0;
        top_new    = cell_frame[0];
        do_push    = 1'b0;
        do_pop     = 1'b0;
        body       = '0;
        body_n     = '0;
        if (op == OP_DOC_START)
        begin
            depth_next = '0;
            err_next   = 1'b0;
        end
        else if (!err_reg)
        begin
            case (op)
                OP_MAP_START, OP_SEQ_START:
                begin
                    body[0] = (op == OP_MAP_START) ? CH_LBRACE : CH_LBRACK;
                    body_n  = CNT_W'(1);
                    if (full)
                        err_next = 1'b1;
                    else
                    begin
                        do_push          = 1'b1;
                        top_we           = 1'b1;
                        top_new.role     = (op == OP_MAP_START) ? ROLE_KEY : ROLE_SEQ;
                        top_new.nonempty = 1'b0;
                        depth_next       = depth_reg + DEPTH_W'(1);
                    end
                end
                OP_MAP_END, OP_SEQ_END:
                begin
                    body[0] = (op == OP_MAP_END) ? CH_RBRACE : CH_RBRACK;
                    body_n  = CNT_W'(1);
                    if (has_top)
                    begin
                        do_pop     = 1'b1;
                        top_we     = 1'b1;
                        top_new    = frame_advance(cell_below[0]);
                        depth_next = depth_reg - DEPTH_W'(1);
                    end
                end
                OP_SCALAR_START:
                begin
                    body[0] = CH_QUOTE;
                    body_n  = CNT_W'(1);
                end
                OP_SCALAR_BYTE:
                begin
                    body[0] = CH_BSLASH;
                    body_n  = CNT_W'(2);
                    case (data_byte)
                        CH_QUOTE:  body[1] = CH_QUOTE;
                        CH_BSLASH: body[1] = CH_BSLASH;
                        CTL_BS:    body[1] = CH_LOW_B;
                        CTL_FF:    body[1] = CH_LOW_F;
                        CTL_LF:    body[1] = CH_LOW_N;
                        CTL_CR:    body[1] = CH_LOW_R;
                        CTL_HT:    body[1] = CH_LOW_T;
                        default:
                        begin
                            if (data_byte < CH_SPACE)
                            begin
                                body[1] = CH_LOW_U;
                                body[2] = CH_ZERO;
                                body[3] = CH_ZERO;
                                body[4] = hex_char(data_byte[7:4]);
                                body[5] = hex_char(data_byte[3:0]);
                                body_n  = CNT_W'(6);
                            end
                            else
                            begin
                                body[0] = data_byte;
                                body_n  = CNT_W'(1);
                            end
                        end
                    endcase
                end
                OP_SCALAR_END:
                begin
                    body[0] = CH_QUOTE;
                    body_n  = CNT_W'(1);
                    top_we  = has_top;
                    top_new = frame_advance(cell_frame[0]);
                end
                OP_ALIAS:
                begin
                    body[0] = CH_LOW_N;
                    body[1] = CH_LOW_U;
                    body[2] = CH_LOW_L;
                    body[3] = CH_LOW_L;
                    body_n  = CNT_W'(4);
                    top_we  = has_top;
                    top_new = frame_advance(cell_frame[0]);
                end
                default: body_n = '0;
            endcase
        end
        if (!accept)
        begin
            depth_next = depth_reg;
            err_next   = err_reg;
            top_we     = 1'b0;
            do_push    = 1'b0;
            do_pop     = 1'b0;
        end
    end

    // put the separator in front of the body for node starts
    always_comb
    begin
        load_data.bytes = body;
        load_data.count = body_n;
        load_data.err   = err_next;
        if (sep_en && !err_reg && (op == OP_MAP_START || op == OP_SEQ_START ||
            op == OP_SCALAR_START || op == OP_ALIAS))
        begin
            load_data.bytes = {body[MAX_BYTES-2:0], sep_ch};
            load_data.count = body_n + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            err_reg   <= err_next;
        end
    end

    // row of frame cells, cell 0 is the top of the stack
    for (genvar i = 0; i < NEST_MAX; i++)
    begin : g_cell
        cell_ctl_t ctl;
        frame_t    above;

        if (i == 0)
        begin : g_head
            assign ctl.load_above = top_we;
            assign ctl.load_below = 1'b0;
            assign above          = top_new;
        end
        else
        begin : g_body
            assign ctl.load_above = do_push;
            assign ctl.load_below = do_pop;
            assign above          = cell_frame[i-1];
        end

        if (i == NEST_MAX - 1)
        begin : g_tail
            assign cell_below[i] = cell_frame[i];
        end
        else
        begin : g_link
            assign cell_below[i] = cell_frame[i+1];
        end

        ejs_frame_cell u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .above (above),
            .below (cell_below[i]),
            .frame (cell_frame[i])
        );
    end

    // output byte line
    ejs_out_queue u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (accept && (load_data.count != '0)),
        .load_data      (load_data),
        .free           (free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .last           (last),
        .overflow_error (overflow_error)
    );

    // depth never passes the stack size
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(NEST_MAX))
        else $error("nesting depth beyond stack size");

    // doc start clears depth and error
    a_doc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_DOC_START) |=> (depth_reg == '0 && !err_reg))
        else $error("doc start did not clear state");

    // start at full depth raises the sticky error
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !err_reg && full && (op == OP_MAP_START || op == OP_SEQ_START))
        |=> err_reg)
        else $error("overflow not flagged");

    // while the error is pending the stack does not move
    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && err_reg && op != OP_DOC_START) |=> $stable(depth_reg))
        else $error("stack moved under pending error");

endmodule

>>> hdl/ejs_frame_cell.sv
module ejs_frame_cell
    import ejs_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  frame_t    above,
    input  frame_t    below,
    output frame_t    frame
);

    frame_t frame_reg;

    // push moves frames down, pop moves them up
    always_ff @(posedge clk)
    begin
        if (ctl.load_above)
            frame_reg <= above;
        else if (ctl.load_below)
            frame_reg <= below;
    end

    assign frame = frame_reg;

endmodule

>>> hdl/ejs_out_queue.sv
module ejs_out_queue
    import ejs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  ejs_load_t  load_data,
    output logic       free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       overflow_error
);

    logic [MAX_BYTES-1:0][7:0] bytes_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic [CNT_W-1:0]          rem_next;
    logic                      err_reg;
    logic                      take;

    assign take      = out_valid && out_ready;
    assign out_valid = (rem_reg != '0);
    assign last      = (rem_reg == CNT_W'(1));
    assign free      = !out_valid || (last && out_ready);
    assign out_byte  = bytes_reg[0];
    assign overflow_error = err_reg;

    // remaining word count
    always_comb
    begin
        rem_next = rem_reg;
        if (load)
            rem_next = load_data.count;
        else if (take)
            rem_next = rem_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

    // byte shift line, head byte is the current word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= load_data.bytes;
            err_reg   <= load_data.err;
        end
        else if (take)
        begin
            bytes_reg <= {8'h00, bytes_reg[MAX_BYTES-1:1]};
        end
    end

endmodule

>>> verif/event_stream_json_emitter_unit_tb.sv
module event_stream_json_emitter_unit_tb;
    import ejs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // ops without a name in the package
    localparam logic [3:0] OP_IGNORED  = 4'd9;
    localparam logic [3:0] OP_TOP_CODE = 4'd15;

    localparam logic [15:0][7:0] HEX_LC = "0123456789abcdef";

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int NDIR = 25;
    localparam int PHASE_WORDS = 50;

    // one directed row; txt holds n bytes, first byte in txt[n-1]
    typedef struct packed {
        logic [3:0]      op;
        logic [7:0]      db;
        logic            typed;
        logic [2:0]      n;
        logic [5:0][7:0] txt;
        logic            err;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       err;
    } text_word_t;

    localparam dir_row_t DIR_ROWS [NDIR] = '{
        '{OP_IGNORED,      8'h00,     1'b1, 3'd0, 48'h0,      1'b0},
        '{OP_TOP_CODE,     8'hff,     1'b1, 3'd0, 48'h0,      1'b0},
        '{OP_SCALAR_BYTE,  8'h00,     1'b1, 3'd6, "\\u0000",  1'b0},
        '{OP_SCALAR_BYTE,  8'hff,     1'b1, 3'd1, 48'hff,     1'b0},
        '{OP_SCALAR_BYTE,  8'h1f,     1'b1, 3'd6, "\\u001f",  1'b0},
        '{OP_SCALAR_BYTE,  CH_SPACE,  1'b1, 3'd1, " ",        1'b0},
        '{OP_SCALAR_END,   8'h00,     1'b1, 3'd1, "\"",       1'b0},
        '{OP_MAP_END,      8'h00,     1'b1, 3'd1, "}",        1'b0},
        '{OP_SEQ_END,      8'h00,     1'b1, 3'd1, "]",        1'b0},
        '{OP_ALIAS,        8'h00,     1'b1, 3'd4, "null",     1'b0},
        '{OP_MAP_START,    8'h00,     1'b1, 3'd1, "{",        1'b0},
        '{OP_SCALAR_START, 8'h00,     1'b0, 3'd0, 48'h0,      1'b0},
        '{OP_SCALAR_BYTE,  CH_QUOTE,  1'b1, 3'd2, "\\\"",     1'b0},
        '{OP_SCALAR_BYTE,  CH_BSLASH, 1'b1, 3'd2, "\\\\",     1'b0},
        '{OP_SCALAR_BYTE,  CTL_BS,    1'b1, 3'd2, "\\b",      1'b0},
        '{OP_SCALAR_BYTE,  CTL_FF,    1'b1, 3'd2, "\\f",      1'b0},
        '{OP_SCALAR_BYTE,  CTL_LF,    1'b1, 3'd2, "\\n",      1'b0},
        '{OP_SCALAR_BYTE,  CTL_CR,    1'b1, 3'd2, "\\r",      1'b0},
        '{OP_SCALAR_BYTE,  CTL_HT,    1'b1, 3'd2, "\\t",      1'b0},
        '{OP_SCALAR_END,   8'h00,     1'b0, 3'd0, 48'h0,      1'b0},
        '{OP_SEQ_START,    8'h00,     1'b0, 3'd0, 48'h0,      1'b0},
        '{OP_ALIAS,        8'h00,     1'b0, 3'd0, 48'h0,      1'b0},
        '{OP_ALIAS,        8'h00,     1'b0, 3'd0, 48'h0,      1'b0},
        '{OP_SEQ_END,      8'h00,     1'b0, 3'd0, 48'h0,      1'b0},
        '{OP_MAP_END,      8'h00,     1'b0, 3'd0, 48'h0,      1'b0}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [3:0] op = '0;
    logic [7:0] data_byte = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       last;
    logic       overflow_error;

    // sideband that travels with a directed word
    logic            row_typed = 1'b0;
    logic [2:0]      row_n = '0;
    logic [5:0][7:0] row_txt = '0;
    logic            row_err = 1'b0;

    // predictor state
    role_t       frame_role [NEST_MAX];
    logic        frame_nonempty [NEST_MAX];
    int unsigned nest_lvl = 0;
    logic        err_flag = 1'b0;
    logic [7:0]  text_buf [6];
    int unsigned text_len;

    text_word_t  json_text_q [$];
    int unsigned words_sent = 0;
    int unsigned words_in = 0;
    int unsigned words_out = 0;
    int unsigned mismatches = 0;
    int unsigned max_lvl = 0;
    int unsigned overflows = 0;
    int unsigned idle_cnt = 0;

    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned hold_left = 0;

    event_stream_json_emitter_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .last           (last),
        .overflow_error (overflow_error)
    );

    always #5 clk = ~clk;

    // text buffer for one word
    function automatic void put_text(logic [7:0] b);
        if (text_len < 6)
        begin
            text_buf[text_len] = b;
            text_len++;
        end
    endfunction

    // comma or colon ahead of a node
    function automatic void put_sep();
        if (nest_lvl != 0)
        begin
            case (frame_role[nest_lvl-1])
                ROLE_KEY, ROLE_SEQ:
                begin
                    if (frame_nonempty[nest_lvl-1])
                        put_text(CH_COMMA);
                end
                ROLE_VALUE: put_text(CH_COLON);
                default: ;
            endcase
        end
    endfunction

    // top frame after a node completes
    function automatic void frame_done();
        if (nest_lvl != 0)
        begin
            case (frame_role[nest_lvl-1])
                ROLE_KEY: frame_role[nest_lvl-1] = ROLE_VALUE;
                ROLE_VALUE:
                begin
                    frame_role[nest_lvl-1] = ROLE_KEY;
                    frame_nonempty[nest_lvl-1] = 1'b1;
                end
                ROLE_SEQ: frame_nonempty[nest_lvl-1] = 1'b1;
                default: ;
            endcase
        end
    endfunction

    function automatic void frame_push(role_t r);
        if (nest_lvl >= NEST_MAX)
        begin
            err_flag = 1'b1;
            overflows++;
        end
        else
        begin
            frame_role[nest_lvl] = r;
            frame_nonempty[nest_lvl] = 1'b0;
            nest_lvl++;
            if (nest_lvl > max_lvl)
                max_lvl = nest_lvl;
        end
    endfunction

    function automatic void frame_pop();
        if (nest_lvl != 0)
            nest_lvl--;
    endfunction

    // json text that one word turns into
    function automatic void json_predict(logic [3:0] o, logic [7:0] b);
        text_len = 0;
        if (o == OP_DOC_START)
        begin
            nest_lvl = 0;
            err_flag = 1'b0;
        end
        else if (o <= OP_ALIAS && !err_flag)
        begin
            case (o)
                OP_MAP_START:
                begin
                    put_sep();
                    put_text(CH_LBRACE);
                    frame_push(ROLE_KEY);
                end
                OP_MAP_END:
                begin
                    frame_pop();
                    put_text(CH_RBRACE);
                    frame_done();
                end
                OP_SEQ_START:
                begin
                    put_sep();
                    put_text(CH_LBRACK);
                    frame_push(ROLE_SEQ);
                end
                OP_SEQ_END:
                begin
                    frame_pop();
                    put_text(CH_RBRACK);
                    frame_done();
                end
                OP_SCALAR_START:
                begin
                    put_sep();
                    put_text(CH_QUOTE);
                end
                OP_SCALAR_BYTE:
                begin
                    case (b)
                        CH_QUOTE, CH_BSLASH:
                        begin
                            put_text(CH_BSLASH);
                            put_text(b);
                        end
                        CTL_BS:
                        begin
                            put_text(CH_BSLASH);
                            put_text(CH_LOW_B);
                        end
                        CTL_FF:
                        begin
                            put_text(CH_BSLASH);
                            put_text(CH_LOW_F);
                        end
                        CTL_LF:
                        begin
                            put_text(CH_BSLASH);
                            put_text(CH_LOW_N);
                        end
                        CTL_CR:
                        begin
                            put_text(CH_BSLASH);
                            put_text(CH_LOW_R);
                        end
                        CTL_HT:
                        begin
                            put_text(CH_BSLASH);
                            put_text(CH_LOW_T);
                        end
                        default:
                        begin
                            if (b < CH_SPACE)
                            begin
                                put_text(CH_BSLASH);
                                put_text(CH_LOW_U);
                                put_text(CH_ZERO);
                                put_text(CH_ZERO);
                                put_text(HEX_LC[15 - b[7:4]]);
                                put_text(HEX_LC[15 - b[3:0]]);
                            end
                            else
                                put_text(b);
                        end
                    endcase
                end
                OP_SCALAR_END:
                begin
                    put_text(CH_QUOTE);
                    frame_done();
                end
                default:
                begin
                    put_sep();
                    put_text(CH_LOW_N);
                    put_text(CH_LOW_U);
                    put_text(CH_LOW_L);
                    put_text(CH_LOW_L);
                    frame_done();
                end
            endcase
        end
    endfunction

    // scalar content, biased toward bytes that need escaping
    function automatic logic [7:0] pick_content_byte();
        logic [7:0] specials [7];
        int unsigned r;
        specials = '{CH_QUOTE, CH_BSLASH, CTL_BS, CTL_HT, CTL_LF, CTL_FF, CTL_CR};
        r = $urandom_range(0, 99);
        if (r < 30)
            return specials[$urandom_range(0, 6)];
        else if (r < 50)
            return 8'($urandom_range(0, 31));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // offer one input word, with random gaps, until it is taken
    task automatic send_word(input logic [3:0] o, input logic [7:0] b,
                             input logic typed = 1'b0, input logic [2:0] n = '0,
                             input logic [47:0] txt = '0, input logic err = 1'b0);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        data_byte <= b;
        row_typed <= typed;
        row_n     <= n;
        row_txt   <= txt;
        row_err   <= err;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // sender pause until all text has come out
    task automatic drain_text();
        in_valid <= 1'b0;
        @(posedge clk);
        while (json_text_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one document of well formed events with random content and some noise
    task automatic gen_doc(input bit deep);
        role_t       kinds [$];
        role_t       top;
        int unsigned nodes;
        int unsigned max_nodes;
        int unsigned pushp;
        int unsigned r;
        int unsigned nb;
        int unsigned i;
        bit          done;
        bit          completed;
        nodes = 0;
        done = 1'b0;
        max_nodes = deep ? 400 : $urandom_range(2, 30);
        pushp = deep ? 90 : 40;
        send_word(OP_DOC_START, 8'($urandom_range(0, 255)));
        while (!done)
        begin
            completed = 1'b0;
            top = (kinds.size() != 0) ? kinds[kinds.size()-1] : ROLE_NONE;
            r = $urandom_range(0, 99);
            if (r < 4)
                send_word(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            else if (deep && kinds.size() > NEST_MAX)
                done = 1'b1;
            else if (kinds.size() == 0 && nodes > 0 && (nodes >= max_nodes || r < 30))
                done = 1'b1;
            else if (top != ROLE_NONE && top != ROLE_VALUE &&
                     (nodes >= max_nodes || $urandom_range(0, 99) < (deep ? 3 : 25)))
            begin
                send_word((top == ROLE_SEQ) ? OP_SEQ_END : OP_MAP_END,
                          8'($urandom_range(0, 255)));
                kinds.pop_back();
                completed = 1'b1;
            end
            else if (top == ROLE_KEY || nodes >= max_nodes || $urandom_range(0, 99) >= pushp)
            begin
                if (top != ROLE_KEY && $urandom_range(0, 99) < 25)
                    send_word(OP_ALIAS, 8'($urandom_range(0, 255)));
                else
                begin
                    send_word(OP_SCALAR_START, 8'($urandom_range(0, 255)));
                    nb = $urandom_range(0, 4);
                    for (i = 0; i < nb; i++)
                        send_word(OP_SCALAR_BYTE, pick_content_byte());
                    send_word(OP_SCALAR_END, 8'($urandom_range(0, 255)));
                end
                nodes++;
                completed = 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_word(OP_MAP_START, 8'($urandom_range(0, 255)));
                    kinds.push_back(ROLE_KEY);
                end
                else
                begin
                    send_word(OP_SEQ_START, 8'($urandom_range(0, 255)));
                    kinds.push_back(ROLE_SEQ);
                end
                nodes++;
            end
            // enclosing mapping moves between key and value
            if (completed && kinds.size() != 0)
            begin
                if (kinds[kinds.size()-1] == ROLE_KEY)
                    kinds[kinds.size()-1] = ROLE_VALUE;
                else if (kinds[kinds.size()-1] == ROLE_VALUE)
                    kinds[kinds.size()-1] = ROLE_KEY;
            end
        end
    endtask

    // receiver ready, with the long hold counted here
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end

    // accepted words: predict on input, compare on output
    always @(posedge clk)
    begin : monitor
        text_word_t w;
        text_word_t got;
        int unsigned k;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                json_predict(op, data_byte);
                words_in++;
                if (row_typed)
                begin
                    for (k = 0; k < row_n; k++)
                    begin
                        w.out_byte = row_txt[row_n-1-k];
                        w.last = (k == row_n - 1);
                        w.err = row_err;
                        json_text_q.push_back(w);
                    end
                end
                else
                begin
                    for (k = 0; k < text_len; k++)
                    begin
                        w.out_byte = text_buf[k];
                        w.last = (k == text_len - 1);
                        w.err = err_flag;
                        json_text_q.push_back(w);
                    end
                end
            end
            if (out_valid && out_ready)
            begin
                words_out++;
                got.out_byte = out_byte;
                got.last = last;
                got.err = overflow_error;
                if (json_text_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output word: byte %h last %b err %b",
                                 got.out_byte, got.last, got.err);
                end
                else
                begin
                    w = json_text_q.pop_front();
                    if (got !== w)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected byte %h last %b err %b, ",
                                      "got byte %h last %b err %b"},
                                     w.out_byte, w.last, w.err,
                                     got.out_byte, got.last, got.err);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned in_pct [4];
        int unsigned out_pct [4];
        int unsigned i;
        int unsigned p;
        int unsigned target;
        in_pct  = '{0, 70, 0, 13};
        out_pct = '{0, 0, 70, 13};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < NDIR; i++)
            send_word(DIR_ROWS[i].op, DIR_ROWS[i].db, DIR_ROWS[i].typed,
                      DIR_ROWS[i].n, DIR_ROWS[i].txt, DIR_ROWS[i].err);

        // fill the stack under a long receiver hold, then overflow it
        send_word(OP_DOC_START, 8'h00, 1'b1, 3'd0, 48'h0, 1'b0);
        hold_req = 1'b1;
        for (i = 0; i < NEST_MAX; i++)
            send_word(OP_SEQ_START, 8'($urandom_range(0, 255)));
        send_word(OP_MAP_START, 8'h00, 1'b1, 3'd1, "{", 1'b1);
        send_word(OP_ALIAS, 8'h00, 1'b1, 3'd0, 48'h0, 1'b0);
        send_word(OP_SCALAR_BYTE, 8'h41, 1'b1, 3'd0, 48'h0, 1'b0);
        send_word(OP_SEQ_END, 8'h00, 1'b1, 3'd0, 48'h0, 1'b0);
        send_word(OP_DOC_START, 8'hff, 1'b1, 3'd0, 48'h0, 1'b0);
        // mismatched end pops the sequence with a brace
        send_word(OP_SEQ_START, 8'h00);
        send_word(OP_MAP_END, 8'h00);
        send_word(OP_DOC_START, 8'h00, 1'b1, 3'd0, 48'h0, 1'b0);
        send_word(OP_ALIAS, 8'h00, 1'b1, 3'd4, "null", 1'b0);
        drain_text();

        // random documents under each idling mix
        for (p = 0; p < 4; p++)
        begin
            in_idle_pct = in_pct[p];
            out_stall_pct = out_pct[p];
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                gen_doc(1'b0);
            drain_text();
        end

        in_idle_pct = 0;
        out_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input words and %0d output words, nesting up to %0d",
                 words_in, words_out, max_lvl);
        $display("stack overflows hit %0d times, %0d mismatches", overflows, mismatches);
        if (mismatches == 0 && json_text_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
